[rtl/core/csfd_pkg.sv]
// Shared types, constants and saturating arithmetic for the CAN signal field decoder.
// No dependencies; used by csfd_extract and can_signal_field_decode.
`default_nettype none

package csfd_pkg;

    // Number of payload bits that a field may occupy.
    localparam int unsigned PAYLOAD_BITS = 64;

    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned SCALE_W   = 32;
    localparam int unsigned PARAM_W   = 48;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned PP_W      = 65;
    localparam int unsigned FULL_W    = 97;

    // Packed input item layout on s_tdata.
    localparam int unsigned IN_DATA_W = 256;
    localparam int unsigned OFS_START = 64;
    localparam int unsigned OFS_LEN   = 70;
    localparam int unsigned OFS_ORDER = 76;
    localparam int unsigned OFS_SCALE = 77;
    localparam int unsigned OFS_OFFS  = 109;
    localparam int unsigned OFS_RMIN  = 157;
    localparam int unsigned OFS_RMAX  = 205;

    typedef struct packed {
        logic                   error;
        logic [PAYLOAD_W-1:0]   raw;
    } csfd_field_t;

    // Signed 64-bit add that clamps to the signed 64-bit range.
    function automatic logic signed [VALUE_W-1:0] sat_add(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        logic signed [VALUE_W:0] s;
        logic signed [VALUE_W-1:0] r;
        begin
            s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
            if (s[VALUE_W] != s[VALUE_W-1])
            begin
                r = s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
            end
            else
            begin
                r = s[VALUE_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/csfd_extract.sv]
// Field extraction, range check and minimal-width byte reversal of the raw value.
// Depends on csfd_pkg.
`default_nettype none

module csfd_extract (
    input  wire logic [csfd_pkg::PAYLOAD_W-1:0] payload,
    input  wire logic [csfd_pkg::POS_W-1:0]     start_bit,
    input  wire logic [csfd_pkg::POS_W-1:0]     bit_length,
    input  wire logic                           byte_order,
    output csfd_pkg::csfd_field_t               field
);

    logic [csfd_pkg::PAYLOAD_W-1:0] shifted;
    logic [csfd_pkg::PAYLOAD_W-1:0] raw;
    logic [csfd_pkg::PAYLOAD_W-1:0] swapped;
    logic [csfd_pkg::POS_W:0]       end_pos;
    logic [csfd_pkg::POS_W:0]       right_shift;
    logic [3:0]                     nbytes;
    logic [3:0]                     src_idx;

    always_comb
    begin
        end_pos     = {1'b0, start_bit} + {1'b0, bit_length};
        right_shift = 7'd64 - {1'b0, bit_length};
        shifted     = payload << start_bit;
        raw         = shifted >> right_shift;

        // The byte count is set by the highest nonzero byte; zero has no bytes.
        nbytes = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (raw[8*i +: 8] != 8'h00)
            begin
                nbytes = 4'(i + 1);
            end
        end

        swapped = '0;
        src_idx = 4'd0;
        for (int j = 0; j < 8; j++)
        begin
            src_idx = nbytes - 4'd1 - 4'(j);
            if (4'(j) < nbytes)
            begin
                swapped[8*j +: 8] = raw[8*src_idx[2:0] +: 8];
            end
        end

        field.error = (bit_length == '0) || (end_pos > 7'(csfd_pkg::PAYLOAD_BITS));
        field.raw   = byte_order ? swapped : raw;
    end

endmodule

`default_nettype wire

[rtl/core/can_signal_field_decode.sv]
// Top level of the CAN signal field decoder: stream ports and the arithmetic pipeline.
// Depends on csfd_pkg and csfd_extract.
`default_nettype none

// Decodes one signal per item: the field is cut from the 8-byte payload (bit 0 is the
// MSB of the first byte), optionally byte reversed over its minimal width, scaled by a
// Q16.16 factor, offset, and folded into its range, giving a saturated Q47.16 value.
// An empty field or one that runs past the payload gives 0 with the error flag set.
// The block takes one item every cycle while the output does not stall it, and each
// item passes seven registers: the input register, the extraction stage, the
// partial products of the scale and the 32-bit halves of the raw value, their
// recombination and saturation, the offset add and the two range corrections. Each
// stage holds its item only while the stage after it is full, so bubbles are squeezed
// out under output backpressure.
module can_signal_field_decode (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // payload[63:0], start_bit[69:64], bit_length[75:70], byte_order[76],
    // scale_factor[108:77], offset_value[156:109], range_min[204:157],
    // range_max[252:205], zero fill [255:253]
    input  wire logic [csfd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // value[63:0]
    output logic [csfd_pkg::VALUE_W-1:0]         m_tdata,
    // error[0]
    output logic                                 m_tuser
);

    localparam int unsigned STAGES = 7;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    // Stage 0: input register.
    logic [csfd_pkg::PAYLOAD_W-1:0]       payload_reg;
    logic [csfd_pkg::POS_W-1:0]           start_bit_reg;
    logic [csfd_pkg::POS_W-1:0]           bit_length_reg;
    logic                                 byte_order_reg;
    logic signed [csfd_pkg::SCALE_W-1:0]  scale0_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  offs0_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmin0_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmax0_reg;

    // Stage 1: raw value.
    csfd_pkg::csfd_field_t                field_next;
    logic [csfd_pkg::PAYLOAD_W-1:0]       raw1_reg;
    logic                                 err1_reg;
    logic signed [csfd_pkg::SCALE_W-1:0]  scale1_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  offs1_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmin1_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmax1_reg;

    // Stage 2: partial products.
    logic signed [csfd_pkg::PP_W-1:0]     pp_lo_next;
    logic signed [csfd_pkg::PP_W-1:0]     pp_hi_next;
    logic signed [csfd_pkg::PP_W-1:0]     pp_lo_reg;
    logic signed [csfd_pkg::PP_W-1:0]     pp_hi_reg;
    logic                                 err2_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  offs2_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmin2_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmax2_reg;

    // Stage 3: saturated product.
    logic signed [csfd_pkg::FULL_W-1:0]   full_prod;
    logic signed [csfd_pkg::VALUE_W-1:0]  prod_next;
    logic signed [csfd_pkg::VALUE_W-1:0]  prod_reg;
    logic                                 err3_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  offs3_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmin3_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmax3_reg;

    // Stage 4: offset added.
    logic signed [csfd_pkg::VALUE_W-1:0]  sum_next;
    logic signed [csfd_pkg::VALUE_W-1:0]  sum_reg;
    logic                                 err4_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmin4_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmax4_reg;

    // Stage 5: upper fold.
    logic signed [csfd_pkg::VALUE_W-1:0]  rmin4_ext;
    logic signed [csfd_pkg::VALUE_W-1:0]  rmax4_ext;
    logic signed [csfd_pkg::VALUE_W-1:0]  fold_next;
    logic signed [csfd_pkg::VALUE_W-1:0]  fold_reg;
    logic                                 err5_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmin5_reg;
    logic signed [csfd_pkg::PARAM_W-1:0]  rmax5_reg;

    // Stage 6: output register.
    logic signed [csfd_pkg::VALUE_W-1:0]  rmin5_ext;
    logic signed [csfd_pkg::VALUE_W-1:0]  rmax5_ext;
    logic signed [csfd_pkg::VALUE_W-1:0]  value_next;
    logic signed [csfd_pkg::VALUE_W-1:0]  value_reg;
    logic                                 err6_reg;

    // A stage may load when it is empty or its item moves on in the same cycle.
    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = value_reg;
    assign m_tuser  = err6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    csfd_extract u_extract (
        .payload    (payload_reg),
        .start_bit  (start_bit_reg),
        .bit_length (bit_length_reg),
        .byte_order (byte_order_reg),
        .field      (field_next)
    );

    always_comb
    begin
        pp_lo_next = $signed({{(csfd_pkg::PP_W-csfd_pkg::SCALE_W){scale1_reg[csfd_pkg::SCALE_W-1]}},
                              scale1_reg})
                   * $signed({{(csfd_pkg::PP_W-csfd_pkg::HALF_W){1'b0}},
                              raw1_reg[csfd_pkg::HALF_W-1:0]});
        pp_hi_next = $signed({{(csfd_pkg::PP_W-csfd_pkg::SCALE_W){scale1_reg[csfd_pkg::SCALE_W-1]}},
                              scale1_reg})
                   * $signed({{(csfd_pkg::PP_W-csfd_pkg::HALF_W){1'b0}},
                              raw1_reg[csfd_pkg::PAYLOAD_W-1:csfd_pkg::HALF_W]});

        full_prod = ($signed({{(csfd_pkg::FULL_W-csfd_pkg::PP_W){pp_hi_reg[csfd_pkg::PP_W-1]}},
                              pp_hi_reg}) <<< csfd_pkg::HALF_W)
                  + $signed({{(csfd_pkg::FULL_W-csfd_pkg::PP_W){pp_lo_reg[csfd_pkg::PP_W-1]}},
                             pp_lo_reg});
        // The product fits when every bit above bit 63 repeats the sign.
        if (full_prod[csfd_pkg::FULL_W-1:csfd_pkg::VALUE_W-1]
            == {(csfd_pkg::FULL_W-csfd_pkg::VALUE_W+1){full_prod[csfd_pkg::VALUE_W-1]}})
        begin
            prod_next = full_prod[csfd_pkg::VALUE_W-1:0];
        end
        else
        begin
            prod_next = full_prod[csfd_pkg::FULL_W-1]
                      ? {1'b1, {(csfd_pkg::VALUE_W-1){1'b0}}}
                      : {1'b0, {(csfd_pkg::VALUE_W-1){1'b1}}};
        end

        sum_next = csfd_pkg::sat_add(
            {{(csfd_pkg::VALUE_W-csfd_pkg::PARAM_W){offs3_reg[csfd_pkg::PARAM_W-1]}}, offs3_reg},
            prod_reg);

        rmin4_ext = {{(csfd_pkg::VALUE_W-csfd_pkg::PARAM_W){rmin4_reg[csfd_pkg::PARAM_W-1]}},
                     rmin4_reg};
        rmax4_ext = {{(csfd_pkg::VALUE_W-csfd_pkg::PARAM_W){rmax4_reg[csfd_pkg::PARAM_W-1]}},
                     rmax4_reg};
        fold_next = (sum_reg > rmax4_ext) ? csfd_pkg::sat_add(sum_reg, -rmin4_ext) : sum_reg;

        rmin5_ext = {{(csfd_pkg::VALUE_W-csfd_pkg::PARAM_W){rmin5_reg[csfd_pkg::PARAM_W-1]}},
                     rmin5_reg};
        rmax5_ext = {{(csfd_pkg::VALUE_W-csfd_pkg::PARAM_W){rmax5_reg[csfd_pkg::PARAM_W-1]}},
                     rmax5_reg};
        if (err5_reg)
        begin
            value_next = '0;
        end
        else if (fold_reg < rmin5_ext)
        begin
            value_next = csfd_pkg::sat_add(fold_reg, rmax5_ext);
        end
        else
        begin
            value_next = fold_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && s_tvalid)
        begin
            payload_reg    <= s_tdata[csfd_pkg::PAYLOAD_W-1:0];
            start_bit_reg  <= s_tdata[csfd_pkg::OFS_START +: csfd_pkg::POS_W];
            bit_length_reg <= s_tdata[csfd_pkg::OFS_LEN +: csfd_pkg::POS_W];
            byte_order_reg <= s_tdata[csfd_pkg::OFS_ORDER];
            scale0_reg     <= s_tdata[csfd_pkg::OFS_SCALE +: csfd_pkg::SCALE_W];
            offs0_reg      <= s_tdata[csfd_pkg::OFS_OFFS +: csfd_pkg::PARAM_W];
            rmin0_reg      <= s_tdata[csfd_pkg::OFS_RMIN +: csfd_pkg::PARAM_W];
            rmax0_reg      <= s_tdata[csfd_pkg::OFS_RMAX +: csfd_pkg::PARAM_W];
        end
        if (adv[1] && valid_reg[0])
        begin
            raw1_reg   <= field_next.raw;
            err1_reg   <= field_next.error;
            scale1_reg <= scale0_reg;
            offs1_reg  <= offs0_reg;
            rmin1_reg  <= rmin0_reg;
            rmax1_reg  <= rmax0_reg;
        end
        if (adv[2] && valid_reg[1])
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            err2_reg  <= err1_reg;
            offs2_reg <= offs1_reg;
            rmin2_reg <= rmin1_reg;
            rmax2_reg <= rmax1_reg;
        end
        if (adv[3] && valid_reg[2])
        begin
            prod_reg  <= prod_next;
            err3_reg  <= err2_reg;
            offs3_reg <= offs2_reg;
            rmin3_reg <= rmin2_reg;
            rmax3_reg <= rmax2_reg;
        end
        if (adv[4] && valid_reg[3])
        begin
            sum_reg   <= sum_next;
            err4_reg  <= err3_reg;
            rmin4_reg <= rmin3_reg;
            rmax4_reg <= rmax3_reg;
        end
        if (adv[5] && valid_reg[4])
        begin
            fold_reg  <= fold_next;
            err5_reg  <= err4_reg;
            rmin5_reg <= rmin4_reg;
            rmax5_reg <= rmax4_reg;
        end
        if (adv[6] && valid_reg[5])
        begin
            value_reg <= value_next;
            err6_reg  <= err5_reg;
        end
    end

endmodule

`default_nettype wire

[bench/can_signal_field_decode_tb.sv]
// Self-checking bench for can_signal_field_decode: directed rows, then random signal descriptors.
// Results are predicted in the bench and checked in order; depends on csfd_pkg and the block.
`default_nettype none

module can_signal_field_decode_tb;

    localparam logic ERR_NONE  = 1'b0;
    localparam logic ERR_FIELD = 1'b1;

    localparam logic signed [csfd_pkg::SCALE_W-1:0] SCALE_ONE = 32'sh0001_0000;
    localparam logic signed [csfd_pkg::SCALE_W-1:0] SCALE_MIN = 32'sh8000_0000;
    localparam logic signed [csfd_pkg::SCALE_W-1:0] SCALE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [csfd_pkg::PARAM_W-1:0] PARAM_MIN = 48'sh8000_0000_0000;
    localparam logic signed [csfd_pkg::PARAM_W-1:0] PARAM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [csfd_pkg::VALUE_W-1:0] VALUE_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [csfd_pkg::VALUE_W-1:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam int PIPE_DRAIN   = 20;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEMS_PHASE  = 90;
    localparam int NUM_PHASES   = 5;
    localparam int NUM_DIRECTED = 20;

    typedef struct {
        logic [csfd_pkg::PAYLOAD_W-1:0]      payload;
        logic [csfd_pkg::POS_W-1:0]          start_bit;
        logic [csfd_pkg::POS_W-1:0]          bit_length;
        logic                                byte_order;
        logic signed [csfd_pkg::SCALE_W-1:0] scale_factor;
        logic signed [csfd_pkg::PARAM_W-1:0] offset_value;
        logic signed [csfd_pkg::PARAM_W-1:0] range_min;
        logic signed [csfd_pkg::PARAM_W-1:0] range_max;
    } signal_item_t;

    typedef struct {
        logic signed [csfd_pkg::VALUE_W-1:0] value;
        logic                                error;
    } signal_result_t;

    typedef struct {
        signal_item_t                        stim;
        bit                                  typed;
        logic signed [csfd_pkg::VALUE_W-1:0] typed_value;
        logic                                typed_error;
    } directed_row_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [csfd_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [csfd_pkg::VALUE_W-1:0]     m_tdata;
    logic                             m_tuser;

    signal_result_t pending_results[$];
    int failures = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    int src_idle_by_phase[NUM_PHASES]   = '{0, 88, 0, 28, 0};
    int sink_stall_by_phase[NUM_PHASES] = '{0, 0, 88, 28, 0};

    directed_row_t directed_rows[NUM_DIRECTED] = '{
        '{'{'1, 6'd0, 6'd0, 1'b0, SCALE_ONE, 48'sd0, PARAM_MIN, PARAM_MAX},
          1'b1, 64'sd0, ERR_FIELD},
        '{'{'1, 6'd63, 6'd2, 1'b0, SCALE_ONE, 48'sd0, PARAM_MIN, PARAM_MAX},
          1'b1, 64'sd0, ERR_FIELD},
        '{'{'1, 6'd63, 6'd63, 1'b1, SCALE_MAX, PARAM_MAX, PARAM_MIN, PARAM_MAX},
          1'b1, 64'sd0, ERR_FIELD},
        '{'{'1, 6'd0, 6'd63, 1'b0, SCALE_ONE, 48'sd0, PARAM_MIN, PARAM_MAX},
          1'b1, VALUE_MAX, ERR_NONE},
        '{'{'1, 6'd1, 6'd63, 1'b0, SCALE_MIN, 48'sd0, PARAM_MIN, PARAM_MAX},
          1'b1, 64'sh8000_7FFF_FFFF_FFFF, ERR_NONE},
        '{'{64'd1, 6'd63, 6'd1, 1'b0, SCALE_ONE, 48'sd0, PARAM_MIN, PARAM_MAX},
          1'b1, 64'sh1_0000, ERR_NONE},
        '{'{64'd0, 6'd8, 6'd40, 1'b1, SCALE_ONE, 48'sh5_0000, PARAM_MIN, PARAM_MAX},
          1'b0, 64'sd0, ERR_NONE},
        '{'{64'h123, 6'd52, 6'd12, 1'b1, SCALE_ONE, 48'sd0, PARAM_MIN, PARAM_MAX},
          1'b0, 64'sd0, ERR_NONE},
        '{'{64'h0123_4567_89AB_CDEF, 6'd0, 6'd63, 1'b1, SCALE_ONE, 48'sd0,
            PARAM_MIN, PARAM_MAX}, 1'b0, 64'sd0, ERR_NONE},
        '{'{64'h0123_4567_89AB_CDEF, 6'd0, 6'd63, 1'b0, 32'sh0000_0001, 48'sd0,
            PARAM_MIN, PARAM_MAX}, 1'b0, 64'sd0, ERR_NONE},
        '{'{64'hFEDC_BA98_7654_3210, 6'd1, 6'd63, 1'b1, 32'sh0000_0001, 48'sd0,
            PARAM_MIN, PARAM_MAX}, 1'b0, 64'sd0, ERR_NONE},
        '{'{64'd200, 6'd56, 6'd8, 1'b0, SCALE_ONE, 48'sd0, 48'sh0A_0000, 48'sh64_0000},
          1'b0, 64'sd0, ERR_NONE},
        '{'{64'd50, 6'd56, 6'd8, 1'b0, -SCALE_ONE, 48'sd0, 48'shFFFF_FFF6_0000,
            48'sh64_0000}, 1'b0, 64'sd0, ERR_NONE},
        '{'{64'd77, 6'd56, 6'd8, 1'b0, SCALE_ONE, 48'sh3_0000, 48'sh64_0000,
            48'sh0A_0000}, 1'b0, 64'sd0, ERR_NONE},
        '{'{'1, 6'd31, 6'd33, 1'b0, SCALE_MAX, PARAM_MAX, PARAM_MIN, PARAM_MAX},
          1'b0, 64'sd0, ERR_NONE},
        '{'{'1, 6'd32, 6'd32, 1'b0, SCALE_MIN, PARAM_MIN, PARAM_MIN, PARAM_MAX},
          1'b0, 64'sd0, ERR_NONE},
        '{'{64'h8000_0000_0000_0000, 6'd0, 6'd1, 1'b0, SCALE_ONE, PARAM_MAX,
            PARAM_MAX, PARAM_MIN}, 1'b0, 64'sd0, ERR_NONE},
        '{'{'1, 6'd10, 6'd20, 1'b1, 32'sd0, PARAM_MIN, PARAM_MIN, PARAM_MAX},
          1'b0, 64'sd0, ERR_NONE},
        '{'{64'h00FF_0000_0000_0000, 6'd8, 6'd24, 1'b1, SCALE_ONE, 48'sd0,
            PARAM_MIN, PARAM_MAX}, 1'b0, 64'sd0, ERR_NONE},
        '{'{64'h5555_AAAA_5555_AAAA, 6'd21, 6'd43, 1'b0, 32'sh0000_0100, 48'sd0,
            48'sh0000_1000_0000, 48'sh0001_0000_0000}, 1'b0, 64'sd0, ERR_NONE}
    };

    can_signal_field_decode dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [csfd_pkg::VALUE_W-1:0] clamp_to_value(
        input logic signed [127:0] x
    );
        if (x[127:csfd_pkg::VALUE_W-1] == '0 || x[127:csfd_pkg::VALUE_W-1] == '1)
            return x[csfd_pkg::VALUE_W-1:0];
        return x[127] ? VALUE_MIN : VALUE_MAX;
    endfunction

    function automatic logic signed [csfd_pkg::VALUE_W-1:0] add_clamped(
        input logic signed [csfd_pkg::VALUE_W-1:0] a,
        input logic signed [csfd_pkg::VALUE_W-1:0] b
    );
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = 128'(a);
        wb = 128'(b);
        return clamp_to_value(wa + wb);
    endfunction

    // Expected decode of one descriptor against its payload.
    function automatic signal_result_t decode_signal(input signal_item_t it);
        signal_result_t                      res;
        logic [csfd_pkg::PAYLOAD_W-1:0]      raw;
        logic [csfd_pkg::PAYLOAD_W-1:0]      rest;
        logic [csfd_pkg::PAYLOAD_W-1:0]      swapped;
        logic signed [127:0]                 wide_scale;
        logic signed [127:0]                 product;
        logic signed [csfd_pkg::VALUE_W-1:0] v;
        logic signed [csfd_pkg::VALUE_W-1:0] lo;
        logic signed [csfd_pkg::VALUE_W-1:0] hi;
        res.value = '0;
        res.error = ERR_FIELD;
        if (it.bit_length == 0
            || int'(it.start_bit) + int'(it.bit_length) > int'(csfd_pkg::PAYLOAD_BITS))
            return res;
        raw = (it.payload << it.start_bit) >> (7'd64 - {1'b0, it.bit_length});
        if (it.byte_order)
        begin
            // Only the bytes that the value actually occupies take part in the swap.
            rest = raw;
            swapped = '0;
            while (rest != 0)
            begin
                swapped = {swapped[csfd_pkg::PAYLOAD_W-9:0], rest[7:0]};
                rest = rest >> 8;
            end
            raw = swapped;
        end
        wide_scale = 128'(it.scale_factor);
        product = wide_scale * $signed({64'd0, raw});
        v = add_clamped(csfd_pkg::VALUE_W'(it.offset_value), clamp_to_value(product));
        lo = csfd_pkg::VALUE_W'(it.range_min);
        hi = csfd_pkg::VALUE_W'(it.range_max);
        if (v > hi)
            v = add_clamped(v, -lo);
        if (v < lo)
            v = add_clamped(v, hi);
        res.value = v;
        res.error = ERR_NONE;
        return res;
    endfunction

    function automatic logic [csfd_pkg::IN_DATA_W-1:0] pack_item(input signal_item_t it);
        logic [csfd_pkg::IN_DATA_W-1:0] d;
        d = '0;
        d[csfd_pkg::PAYLOAD_W-1:0]                     = it.payload;
        d[csfd_pkg::OFS_START +: csfd_pkg::POS_W]      = it.start_bit;
        d[csfd_pkg::OFS_LEN +: csfd_pkg::POS_W]        = it.bit_length;
        d[csfd_pkg::OFS_ORDER]                         = it.byte_order;
        d[csfd_pkg::OFS_SCALE +: csfd_pkg::SCALE_W]    = it.scale_factor;
        d[csfd_pkg::OFS_OFFS +: csfd_pkg::PARAM_W]     = it.offset_value;
        d[csfd_pkg::OFS_RMIN +: csfd_pkg::PARAM_W]     = it.range_min;
        d[csfd_pkg::OFS_RMAX +: csfd_pkg::PARAM_W]     = it.range_max;
        return d;
    endfunction

    function automatic logic signed [csfd_pkg::PARAM_W-1:0] small_param();
        int t;
        t = int'($urandom_range(0, 1 << 24)) - (1 << 23);
        return csfd_pkg::PARAM_W'(t);
    endfunction

    function automatic signal_item_t random_signal_item();
        signal_item_t it;
        int len;
        int t;
        logic signed [csfd_pkg::PARAM_W-1:0] a;
        logic signed [csfd_pkg::PARAM_W-1:0] b;
        it.payload = {$urandom, $urandom};
        case ($urandom_range(15))
            0: it.payload = '0;
            1: it.payload = '1;
            default: ;
        endcase
        if ($urandom_range(9) == 0)
        begin
            // Malformed descriptor: empty field or one running off the payload.
            if ($urandom_range(1) == 0)
            begin
                it.bit_length = '0;
                it.start_bit = csfd_pkg::POS_W'($urandom);
            end
            else
            begin
                len = $urandom_range(2, 63);
                it.bit_length = csfd_pkg::POS_W'(len);
                it.start_bit = csfd_pkg::POS_W'($urandom_range(65 - len, 63));
            end
        end
        else
        begin
            case ($urandom_range(3))
                0: len = $urandom_range(1, 8);
                1: len = $urandom_range(9, 16);
                2: len = $urandom_range(17, 32);
                default: len = $urandom_range(33, 63);
            endcase
            it.bit_length = csfd_pkg::POS_W'(len);
            it.start_bit = csfd_pkg::POS_W'($urandom_range(0, 64 - len));
        end
        it.byte_order = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: it.scale_factor = $urandom;
            1:
            begin
                t = int'($urandom_range(0, 1 << 18)) - (1 << 17);
                it.scale_factor = t;
            end
            2:
            begin
                t = (int'($urandom_range(0, 20)) - 10) * 65536;
                it.scale_factor = t;
            end
            default: it.scale_factor = $urandom_range(1) ? SCALE_MIN : SCALE_MAX;
        endcase
        it.offset_value = $urandom_range(1) ? csfd_pkg::PARAM_W'({$urandom, $urandom})
                                            : small_param();
        a = small_param();
        b = small_param();
        case ($urandom_range(3))
            0:
            begin
                it.range_min = PARAM_MIN;
                it.range_max = PARAM_MAX;
            end
            1:
            begin
                it.range_min = csfd_pkg::PARAM_W'({$urandom, $urandom});
                it.range_max = csfd_pkg::PARAM_W'({$urandom, $urandom});
            end
            2:
            begin
                it.range_min = (a < b) ? a : b;
                it.range_max = (a < b) ? b : a;
            end
            default:
            begin
                it.range_min = a;
                it.range_max = b;
            end
        endcase
        return it;
    endfunction

    // Offers one item after a random idle gap and records its expected result on acceptance.
    task automatic offer_item(input signal_item_t it, input signal_result_t outcome);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_item(it);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(outcome);
    endtask

    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        signal_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: value %h error %b", m_tdata, m_tuser);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, m_tdata);
                    failures++;
                end
                if (m_tuser !== want.error)
                begin
                    $error("error: expected %b, got %b", want.error, m_tuser);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        signal_item_t   it;
        signal_result_t outcome;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            it = directed_rows[i].stim;
            if (directed_rows[i].typed)
            begin
                outcome.value = directed_rows[i].typed_value;
                outcome.error = directed_rows[i].typed_error;
            end
            else
            begin
                outcome = decode_signal(it);
            end
            offer_item(it, outcome);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            src_idle_pct = src_idle_by_phase[phase];
            sink_stall_pct = sink_stall_by_phase[phase];
            // The last phase backs up the output so the pipeline fills and stalls its input.
            if (phase == NUM_PHASES - 1)
                hold_requests++;
            for (int n = 0; n < ITEMS_PHASE; n++)
            begin
                it = random_signal_item();
                offer_item(it, decode_signal(it));
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/core/csfd_pkg.sv
rtl/core/csfd_extract.sv
rtl/core/can_signal_field_decode.sv
bench/can_signal_field_decode_tb.sv
